>>> rtl/stereo_soft_knee_compressor_unit_defines.svh
// assertion helpers for the top-level rtl file
`ifndef STEREO_SOFT_KNEE_COMPRESSOR_UNIT_DEFINES_SVH
`define STEREO_SOFT_KNEE_COMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define SSKC_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define SSKC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/sskc_pkg.sv
// ----------------------------------------------------------------------------
// sskc_pkg
// shared constants, types, fixed-point helpers and rom tables of the
// stereo soft-knee compressor
// ----------------------------------------------------------------------------
`default_nettype none

package sskc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_ENTRIES    = 2 ** LOG_TABLE_BITS;

  localparam int PEAK_FLOOR      = 8;
  localparam int KNEE_HALF       = 768;
  localparam int DB_PER_LOG2_Q16 = 394566;
  localparam int LOG2_PER_DB_Q16 = 10885;
  localparam int GAIN_MIN        = -24576;
  // reciprocal of three in q0.16, exact for the knee quotient range
  localparam int RECIP3_Q16      = 21846;

  localparam int Q23_SHR = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
  localparam int Q23_SHL = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

  // digit-serial multiplier: 32 bit magnitudes, 4 bit digits
  localparam int MUL_WIDTH = 32;
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = MUL_WIDTH / MUL_DIGIT;
  localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);

  // configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD_DB      = 4'd0,
    CFG_SLOPE             = 4'd1,
    CFG_ATTACK_COEF       = 4'd2,
    CFG_RELEASE_COEF      = 4'd3,
    CFG_MAKEUP_CEILING_DB = 4'd4,
    CFG_HP_B0             = 4'd5,
    CFG_HP_A1             = 4'd6,
    CFG_HP_A2             = 4'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BX, ST_A1, ST_A2, ST_ENV1, ST_ENV2, ST_NORM, ST_DB,
    ST_KNEE1, ST_KNEE2, ST_EXP, ST_OUTL, ST_OUTR, ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [15:0]        slope;
    logic [23:0]        attack_coef;
    logic [23:0]        release_coef;
    logic [11:0]        makeup_ceiling_db;
    logic signed [31:0] hp_b0;
    logic signed [31:0] hp_a1;
    logic signed [31:0] hp_a2;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic signed [15:0]            gain_db;
  } res_t;

  typedef logic [15:0] log_rom_t [LOG_ENTRIES];
  typedef logic [31:0] exp_rom_t [LOG_ENTRIES];

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // magnitude rescaled to q1.23, clipped and floored
  function automatic logic [23:0] to_q23(input logic signed [31:0] y);
    logic [32:0] mag;
    logic [39:0] m;
    logic [23:0] r;
    mag = y[31] ? 33'(-34'(y)) : 33'(y);
    m = (40'(mag) >> Q23_SHR) << Q23_SHL;
    if (m > 40'hffffff) r = 24'hffffff;
    else if (m < 40'(PEAK_FLOOR)) r = 24'(PEAK_FLOOR);
    else r = m[23:0];
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^L) in q0.16 by repeated squaring
  function automatic log_rom_t build_log_rom();
    log_rom_t t;
    logic [63:0] m;
    logic [15:0] r;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      m = 64'(LOG_ENTRIES + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r = r | 16'd1;
          m = m >> 1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  // 2^(i/2^L) in q1.30 from products of 2^(2^-k)
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t t;
    logic [63:0] c;
    logic [63:0] p;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      c = isqrt64(64'd1 << 61);
      p = 64'd1 << 30;
      for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
        if (((i >> (LOG_TABLE_BITS - k)) & 1) != 0) p = (p * c + (64'd1 << 29)) >> 30;
        c = isqrt64(c << 30);
      end
      t[i] = p[31:0];
    end
    return t;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

>>> rtl/sskc_if.sv
// ----------------------------------------------------------------------------
// sskc stream interfaces
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface sskc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sskc_pkg::SAMPLE_BITS-1:0] left_in;
  logic signed [sskc_pkg::SAMPLE_BITS-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

interface sskc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sskc_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [sskc_pkg::SAMPLE_BITS-1:0] right_out;
  logic signed [15:0]                     gain_db;
  modport source (output valid, left_out, right_out, gain_db, input ready);
  modport sink (input valid, left_out, right_out, gain_db, output ready);
endinterface

`default_nettype wire

>>> rtl/sskc_serial_mult.sv
// ----------------------------------------------------------------------------
// sskc_serial_mult
// signed multiplier, sign-magnitude, one 4 bit digit of b per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sskc_serial_mult (
  input  wire logic           clk,
  input  wire logic           rst,
  input  sskc_pkg::mul_req_t  req,
  output sskc_pkg::mul_rsp_t  rsp
);

  localparam int W = sskc_pkg::MUL_WIDTH;
  localparam int D = sskc_pkg::MUL_DIGIT;

  logic                                busy;
  logic                                last;
  logic                                done;
  logic [sskc_pkg::MUL_CNT_BITS-1:0]   cnt;
  logic                                neg;
  logic [W-1:0]                        ma;
  logic [2*W-1:0]                      p;
  logic signed [63:0]                  prod;

  logic [32:0]  abs_a;
  logic [32:0]  abs_b;
  logic [W+D-1:0] sum;

  always_comb begin
    abs_a = req.a[32] ? 33'(-req.a) : 33'(req.a);
    abs_b = req.b[32] ? 33'(-req.b) : 33'(req.b);
    // add one partial product to the upper half, shift one digit out below
    sum = (W+D)'(p[2*W-1:W]) + (W+D)'(ma) * (W+D)'(p[D-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      last <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sskc_pkg::MUL_CNT_BITS'(sskc_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          last <= 1'b1;
        end
      end else if (last) begin
        last <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma  <= abs_a[W-1:0];
      p   <= {{W{1'b0}}, abs_b[W-1:0]};
      neg <= req.a[32] ^ req.b[32];
    end else if (busy) begin
      p <= {sum, p[W-1:D]};
    end else if (last) begin
      prod <= neg ? -$signed(p) : $signed(p);
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

`default_nettype wire

>>> rtl/sskc_core.sv
// ----------------------------------------------------------------------------
// sskc_core
// sequencer and datapath: highpass sidechain, envelope, log, knee, exp, gain
// ----------------------------------------------------------------------------
`default_nettype none

module sskc_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  sskc_pkg::cfg_t                             cfg,
  input  wire logic                                  start,
  input  wire logic signed [sskc_pkg::SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [sskc_pkg::SAMPLE_BITS-1:0] right_in,
  input  wire logic                                  slot_free,
  output logic                                       idle,
  output logic                                       fin,
  output sskc_pkg::res_t                             res
);

  localparam int SB = sskc_pkg::SAMPLE_BITS;
  localparam int L  = sskc_pkg::LOG_TABLE_BITS;

  sskc_pkg::state_t state, state_next;
  sskc_pkg::mul_req_t mreq;
  sskc_pkg::mul_rsp_t mrsp;

  logic issued, issued_next;
  logic mul_state;
  logic mul_start;

  // datapath registers
  logic signed [SB-1:0] xs [2];
  logic signed [31:0]   st0 [2];
  logic signed [31:0]   st1 [2];
  logic [23:0]          pk [2];
  logic                 ch;
  logic signed [33:0]   bx;
  logic signed [31:0]   y;
  logic [23:0]          env;
  logic [48:0]          acc1;
  logic [23:0]          enorm;
  logic [4:0]           cnt;
  logic signed [23:0]   l2;
  logic signed [19:0]   over;
  logic [26:0]          t;
  logic signed [19:0]   g;
  logic signed [15:0]   total;
  logic [30:0]          lin;
  logic signed [SB-1:0] ol;
  logic signed [SB-1:0] orr;

  // combinational terms
  logic signed [33:0] shr30;
  logic [23:0]        peak_max;
  logic [23:0]        coef;
  logic [24:0]        coef_inv;
  logic [49:0]        env_sum;
  logic [23:0]        env_new;
  logic signed [63:0] db_sum;
  logic signed [17:0] envdb;
  logic               below;
  logic               knee;
  logic [10:0]        u;
  logic signed [63:0] g_sum;
  logic [13:0]        kv;
  logic [29:0]        kq;
  logic signed [20:0] gr;
  logic signed [20:0] mk;
  logic signed [20:0] tot_raw;
  logic signed [15:0] tot_c;
  logic signed [63:0] e_sum;
  logic signed [23:0] e16;
  logic signed [7:0]  n;
  logic signed [7:0]  sh;
  logic [L-1:0]       eidx;
  logic [31:0]        erom;
  logic signed [63:0] o_sum;

  sskc_serial_mult u_mult (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_comb begin
    shr30    = $signed(mrsp.prod[63:30]);
    peak_max = (pk[0] > pk[1]) ? pk[0] : pk[1];
    coef     = (peak_max > env) ? cfg.attack_coef : cfg.release_coef;
    coef_inv = 25'h1000000 - {1'b0, coef};
    env_sum  = 50'(acc1) + 50'(mrsp.prod[48:0]) + 50'h800000;
    env_new  = env_sum[47:24];
    db_sum   = mrsp.prod + 64'sh800000;
    envdb    = db_sum[41:24];
    below    = over <= -20'sd768;
    knee     = over < 20'sd768;
    u        = 11'(over + 20'sd768);
    g_sum    = mrsp.prod + 64'sd32768;
    // knee quotient: divide by 3 * 2^26 with rounding, as shift then reciprocal
    kv       = 14'((mrsp.prod + 64'sh6000000) >>> 26);
    kq       = 30'(kv) * 30'(sskc_pkg::RECIP3_Q16);
    gr       = -21'(g);
    mk       = (gr < 21'($signed({1'b0, cfg.makeup_ceiling_db})))
               ? gr : 21'($signed({1'b0, cfg.makeup_ceiling_db}));
    tot_raw  = 21'(g) + mk;
    tot_c    = (tot_raw < 21'(sskc_pkg::GAIN_MIN)) ? 16'(sskc_pkg::GAIN_MIN)
                                                   : tot_raw[15:0];
    e_sum    = mrsp.prod + 64'sd128;
    e16      = e_sum[31:8];
    n        = 8'(e16 >>> 16);
    sh       = -n;
    eidx     = e16[15 -: L];
    erom     = sskc_pkg::EXP_ROM[eidx];
    o_sum    = mrsp.prod + 64'sh20000000;
  end

  // operand select for the shared multiplier
  always_comb begin
    mreq.start = mul_start;
    mreq.a = '0;
    mreq.b = '0;
    unique case (state)
      sskc_pkg::ST_BX: begin
        mreq.a = 33'(cfg.hp_b0);
        mreq.b = 33'(xs[ch]);
      end
      sskc_pkg::ST_A1: begin
        mreq.a = 33'(cfg.hp_a1);
        mreq.b = 33'(y);
      end
      sskc_pkg::ST_A2: begin
        mreq.a = 33'(cfg.hp_a2);
        mreq.b = 33'(y);
      end
      sskc_pkg::ST_ENV1: begin
        mreq.a = $signed({9'd0, coef});
        mreq.b = $signed({9'd0, env});
      end
      sskc_pkg::ST_ENV2: begin
        mreq.a = $signed({8'd0, coef_inv});
        mreq.b = $signed({9'd0, peak_max});
      end
      sskc_pkg::ST_DB: begin
        mreq.a = 33'(l2);
        mreq.b = 33'(sskc_pkg::DB_PER_LOG2_Q16);
      end
      sskc_pkg::ST_KNEE1: begin
        if (knee) begin
          mreq.a = $signed({17'd0, cfg.slope});
          mreq.b = $signed({22'd0, u});
        end else begin
          mreq.a = 33'(over);
          mreq.b = $signed({17'd0, cfg.slope});
        end
      end
      sskc_pkg::ST_KNEE2: begin
        mreq.a = $signed({6'd0, t});
        mreq.b = $signed({22'd0, u});
      end
      sskc_pkg::ST_EXP: begin
        mreq.a = 33'(tot_c);
        mreq.b = 33'(sskc_pkg::LOG2_PER_DB_Q16);
      end
      sskc_pkg::ST_OUTL: begin
        mreq.a = 33'(xs[0]);
        mreq.b = $signed({2'd0, lin});
      end
      sskc_pkg::ST_OUTR: begin
        mreq.a = 33'(xs[1]);
        mreq.b = $signed({2'd0, lin});
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sskc_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_state  = 1'b1;
    fin        = 1'b0;
    unique case (state)
      sskc_pkg::ST_IDLE: begin
        mul_state = 1'b0;
        if (start) state_next = sskc_pkg::ST_BX;
      end
      sskc_pkg::ST_BX:    if (mrsp.done) state_next = sskc_pkg::ST_A1;
      sskc_pkg::ST_A1:    if (mrsp.done) state_next = sskc_pkg::ST_A2;
      sskc_pkg::ST_A2: begin
        if (mrsp.done) state_next = ch ? sskc_pkg::ST_ENV1 : sskc_pkg::ST_BX;
      end
      sskc_pkg::ST_ENV1:  if (mrsp.done) state_next = sskc_pkg::ST_ENV2;
      sskc_pkg::ST_ENV2:  if (mrsp.done) state_next = sskc_pkg::ST_NORM;
      sskc_pkg::ST_NORM: begin
        mul_state = 1'b0;
        if (enorm[23]) state_next = sskc_pkg::ST_DB;
      end
      sskc_pkg::ST_DB:    if (mrsp.done) state_next = sskc_pkg::ST_KNEE1;
      sskc_pkg::ST_KNEE1: begin
        if (below) begin
          mul_state  = 1'b0;
          state_next = sskc_pkg::ST_EXP;
        end else if (mrsp.done) begin
          state_next = knee ? sskc_pkg::ST_KNEE2 : sskc_pkg::ST_EXP;
        end
      end
      sskc_pkg::ST_KNEE2: if (mrsp.done) state_next = sskc_pkg::ST_EXP;
      sskc_pkg::ST_EXP:   if (mrsp.done) state_next = sskc_pkg::ST_OUTL;
      sskc_pkg::ST_OUTL:  if (mrsp.done) state_next = sskc_pkg::ST_OUTR;
      sskc_pkg::ST_OUTR:  if (mrsp.done) state_next = sskc_pkg::ST_DONE;
      sskc_pkg::ST_DONE: begin
        mul_state = 1'b0;
        if (slot_free) begin
          fin        = 1'b1;
          state_next = sskc_pkg::ST_IDLE;
        end
      end
      default: state_next = sskc_pkg::ST_IDLE;
    endcase
    mul_start   = mul_state && !issued;
    issued_next = mul_start ? 1'b1 : (mrsp.done ? 1'b0 : issued);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env    <= '0;
      st0[0] <= '0;
      st0[1] <= '0;
      st1[0] <= '0;
      st1[1] <= '0;
      ch     <= 1'b0;
    end else begin
      unique case (state)
        sskc_pkg::ST_IDLE: begin
          if (start) begin
            xs[0] <= left_in;
            xs[1] <= right_in;
            ch    <= 1'b0;
          end
        end
        sskc_pkg::ST_BX: begin
          if (mrsp.done) begin
            bx <= shr30;
            y  <= sskc_pkg::sat32(64'(shr30) + 64'(st0[ch]));
          end
        end
        sskc_pkg::ST_A1: begin
          if (mrsp.done) st0[ch] <= sskc_pkg::sat32(-(64'(bx) <<< 1) - 64'(shr30)
                                                    + 64'(st1[ch]));
        end
        sskc_pkg::ST_A2: begin
          if (mrsp.done) begin
            st1[ch] <= sskc_pkg::sat32(64'(bx) - 64'(shr30));
            pk[ch]  <= sskc_pkg::to_q23(y);
            ch      <= ~ch;
          end
        end
        sskc_pkg::ST_ENV1: if (mrsp.done) acc1 <= mrsp.prod[48:0];
        sskc_pkg::ST_ENV2: begin
          if (mrsp.done) begin
            env   <= env_new;
            // zero envelope takes the log of one
            enorm <= (env_new == '0) ? 24'd1 : env_new;
            cnt   <= '0;
          end
        end
        sskc_pkg::ST_NORM: begin
          if (!enorm[23]) begin
            enorm <= enorm << 1;
            cnt   <= cnt + 1'b1;
          end else begin
            l2 <= $signed({8'd0, sskc_pkg::LOG_ROM[enorm[22 -: L]]})
                  - $signed({3'd0, cnt, 16'd0});
          end
        end
        sskc_pkg::ST_DB: if (mrsp.done) over <= 20'(envdb) - 20'(cfg.threshold_db);
        sskc_pkg::ST_KNEE1: begin
          if (below) g <= '0;
          else if (mrsp.done) begin
            if (knee) t <= mrsp.prod[26:0];
            else g <= -20'(g_sum >>> 16);
          end
        end
        sskc_pkg::ST_KNEE2: if (mrsp.done) g <= -$signed({6'd0, kq[29:16]});
        sskc_pkg::ST_EXP: begin
          if (mrsp.done) begin
            total <= tot_c;
            lin   <= (sh >= 8'sd31) ? 31'd0 : 31'(erom >> sh[4:0]);
          end
        end
        sskc_pkg::ST_OUTL: if (mrsp.done) ol <= o_sum[30+SB-1:30];
        sskc_pkg::ST_OUTR: if (mrsp.done) orr <= o_sum[30+SB-1:30];
        default: begin
        end
      endcase
    end
  end

  assign idle          = (state == sskc_pkg::ST_IDLE);
  assign res.left_out  = ol;
  assign res.right_out = orr;
  assign res.gain_db   = total;

endmodule

`default_nettype wire

>>> rtl/stereo_soft_knee_compressor_unit.sv
// the time from accepted sample word to result word is set by up to fourteen passes
// through the 4 bit digit-serial multiplier (the knee passes skipped below the knee,
// the second one also above it) plus bit-serial log normalisation
// the core takes the next word once the last result sits in the output register
// reset: synchronous, active high; registers to defaults, filter and envelope state zero
`default_nettype none
`include "stereo_soft_knee_compressor_unit_defines.svh"

module stereo_soft_knee_compressor_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  sskc_in_if.sink                                     samples,
  sskc_out_if.source                                  results,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [sskc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [sskc_pkg::CFG_DATA_BITS-1:0]     cfg_wr_data
);

  sskc_pkg::cfg_t cfg;
  sskc_pkg::res_t core_res;

  logic core_idle;
  logic core_fin;
  logic slot_free;
  logic out_valid;
  sskc_pkg::res_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db      <= -16'sd6144;
      cfg.slope             <= '0;
      cfg.attack_coef       <= 24'd16707430;
      cfg.release_coef      <= 24'd16770226;
      cfg.makeup_ceiling_db <= '0;
      cfg.hp_b0             <= 32'sd1061877000;
      cfg.hp_a1             <= -32'sd2123637000;
      cfg.hp_a2             <= 32'sd1050154000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sskc_pkg::CFG_THRESHOLD_DB:      cfg.threshold_db <= cfg_wr_data[15:0];
        sskc_pkg::CFG_SLOPE:             cfg.slope <= cfg_wr_data[15:0];
        sskc_pkg::CFG_ATTACK_COEF:       cfg.attack_coef <= cfg_wr_data[23:0];
        sskc_pkg::CFG_RELEASE_COEF:      cfg.release_coef <= cfg_wr_data[23:0];
        sskc_pkg::CFG_MAKEUP_CEILING_DB: cfg.makeup_ceiling_db <= cfg_wr_data[11:0];
        sskc_pkg::CFG_HP_B0:             cfg.hp_b0 <= cfg_wr_data;
        sskc_pkg::CFG_HP_A1:             cfg.hp_a1 <= cfg_wr_data;
        sskc_pkg::CFG_HP_A2:             cfg.hp_a2 <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  assign samples.ready = core_idle;
  assign slot_free     = !out_valid || results.ready;

  sskc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (samples.valid && core_idle),
    .left_in   (samples.left_in),
    .right_in  (samples.right_in),
    .slot_free (slot_free),
    .idle      (core_idle),
    .fin       (core_fin),
    .res       (core_res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_fin) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_fin) out_word <= core_res;
  end

  assign results.valid     = out_valid;
  assign results.left_out  = out_word.left_out;
  assign results.right_out = out_word.right_out;
  assign results.gain_db   = out_word.gain_db;

  `SSKC_ASSERT_NEXT(a_accept_starts_core, samples.valid && samples.ready, !core_idle,
    "accepted word did not start the core")
  `SSKC_ASSERT_IMPL(a_fin_needs_slot, core_fin, slot_free,
    "core finished into a full output register")
  `SSKC_ASSERT_NEXT(a_fin_loads_output, core_fin, out_valid,
    "finished word not presented")
  `SSKC_ASSERT_IMPL(a_gain_not_positive, out_valid,
    out_word.gain_db[15] || (out_word.gain_db == 16'sd0),
    "total gain above 0 dB")

endmodule

`default_nettype wire
